// ===== rtl/station_time_trimmed_mean_defines.svh =====
// ---------------------------------------------------------------------------
// station_time_trimmed_mean_defines
// Assertion macros shared by the station time filter.
// ---------------------------------------------------------------------------
`ifndef STATION_TIME_TRIMMED_MEAN_DEFINES_SVH
`define STATION_TIME_TRIMMED_MEAN_DEFINES_SVH

// same-cycle implication
`define STM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stm_pkg.sv =====
// ---------------------------------------------------------------------------
// stm_pkg
// Types and constants of the station time trimmed-mean filter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package stm_pkg;

    localparam int TIME_W  = 16;
    localparam int VAL_W   = 15;
    localparam int STA_W   = 4;
    localparam int CFG_W   = 4;
    localparam int SUM_W   = 19;
    localparam int CNT_W   = 5;
    localparam int SLOTS   = 15;

    localparam logic [VAL_W-1:0]  EMPTY_MARK = 15'd30000;
    localparam logic [TIME_W-1:0] TIME_LIMIT = 16'd30000;
    localparam logic [CNT_W-1:0]  GROW_LIMIT = 5'd14;

    localparam logic [1:0] CFG_WINDOW_COUNT = 2'd0;
    localparam logic [1:0] CFG_TRIM_LOW     = 2'd1;
    localparam logic [1:0] CFG_TRIM_HIGH    = 2'd2;
    localparam logic [1:0] CFG_WINDOW_CAP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_LOAD,
        ST_TRIM,
        ST_SUM,
        ST_DSTART,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/stm_hist_mem.sv =====
// ---------------------------------------------------------------------------
// stm_hist_mem
// Sample history memory, one write and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stm_hist_mem #(
    parameter int DEPTH  = 150,
    parameter int ADDR_W = 8
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [stm_pkg::TIME_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [stm_pkg::TIME_W-1:0] rdata
);

    logic [stm_pkg::TIME_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/stm_sort.sv =====
// ---------------------------------------------------------------------------
// stm_sort
// Sorted slot register; each insert places one value in ascending order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stm_sort (
    input  logic                      clk,
    input  logic                      clear,
    input  logic                      ins_valid,
    input  logic [stm_pkg::VAL_W-1:0] ins_data,
    input  logic [3:0]                rd_idx,
    output logic [stm_pkg::VAL_W-1:0] rd_data
);

    logic [stm_pkg::VAL_W-1:0] slot_reg  [stm_pkg::SLOTS];
    logic [stm_pkg::VAL_W-1:0] slot_next [stm_pkg::SLOTS];

    always_comb
    begin
        for (int k = 0; k < stm_pkg::SLOTS; k++)
        begin
            if (slot_reg[k] <= ins_data)
            begin
                slot_next[k] = slot_reg[k];
            end
            else if (k == 0)
            begin
                slot_next[k] = ins_data;
            end
            else if (slot_reg[k-1] <= ins_data)
            begin
                slot_next[k] = ins_data;
            end
            else
            begin
                slot_next[k] = slot_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < stm_pkg::SLOTS; k++)
        begin
            if (clear)
            begin
                slot_reg[k] <= stm_pkg::EMPTY_MARK;
            end
            else if (ins_valid)
            begin
                slot_reg[k] <= slot_next[k];
            end
        end
    end

    assign rd_data = (rd_idx < 4'(stm_pkg::SLOTS)) ? slot_reg[rd_idx] : stm_pkg::EMPTY_MARK;

endmodule

// ===== rtl/stm_div.sv =====
// ---------------------------------------------------------------------------
// stm_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [stm_pkg::SUM_W-1:0] dividend,
    input  logic [3:0]                divisor,
    output logic                      done,
    output logic [stm_pkg::SUM_W-1:0] quotient
);

    logic [4:0]                rem_reg, rem_next;
    logic [stm_pkg::SUM_W-1:0] quo_reg, quo_next;
    logic [3:0]                d_reg;
    logic [4:0]                cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [4:0]                trial;

    always_comb
    begin
        trial     = {rem_reg[3:0], quo_reg[stm_pkg::SUM_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = 5'(stm_pkg::SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                quo_next = {quo_reg[stm_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[stm_pkg::SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/station_time_trimmed_mean.sv =====
// ---------------------------------------------------------------------------
// station_time_trimmed_mean
// Per-station history of run-time samples and trimmed mean of the newest.
// ---------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   tdata: station, sample_time
//  m_       out  m_tvalid / m_tready   tdata: station_out, filtered_time; tuser
//  cfg_     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
//  An item passes accept, history write, memory reads with sorted insert,
//  trim, sum steps, divider start, divider steps plus done, result load;
//  a trim that leaves no divisor goes straight to result load, as do
//  out-of-range stations after accept. History reads as zero after
//  reset through per-station fill counts; no clearing pass.
//  A new item is taken while the previous result waits on m_tready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "station_time_trimmed_mean_defines.svh"

module station_time_trimmed_mean #(
    parameter int STATIONS      = 10,
    parameter int HISTORY_DEPTH = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] station, [19:4] sample_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] station_out, [18:4] filtered_time
    output logic [0:0]  m_tuser,   // [0] no_average
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int SW     = (STATIONS > 1) ? $clog2(STATIONS) : 1;
    localparam int HW     = $clog2(HISTORY_DEPTH);
    localparam int CW     = HW + 1;
    localparam int FW     = $clog2(HISTORY_DEPTH + 1);
    localparam int MDEPTH = STATIONS * HISTORY_DEPTH;
    localparam int ADDR_W = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;

    stm_pkg::state_t state_reg, state_next;

    logic [stm_pkg::CFG_W-1:0]  wcount_reg, tlow_reg, thigh_reg, wcap_reg;
    logic [HW-1:0]              head_reg [STATIONS];
    logic [FW-1:0]              fill_reg [STATIONS];

    logic [stm_pkg::STA_W-1:0]  st_reg, st_next;
    logic [stm_pkg::TIME_W-1:0] sample_reg, sample_next;
    logic [stm_pkg::CNT_W-1:0]  win_reg, win_next;
    logic [stm_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [stm_pkg::CFG_W-1:0]  hi_reg, hi_next;
    logic [stm_pkg::CNT_W-1:0]  ub_reg, ub_next;
    logic [3:0]                 dvs_reg, dvs_next;
    logic [stm_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                       ent_ok_reg, ent_ok_next;
    logic [stm_pkg::SUM_W-1:0]  sum_reg, sum_next;
    logic [stm_pkg::VAL_W-1:0]  res_time_reg, res_time_next;
    logic                       res_na_reg, res_na_next;

    logic                       out_valid_reg, out_valid_next;
    logic [stm_pkg::STA_W-1:0]  out_st_reg;
    logic [stm_pkg::VAL_W-1:0]  out_time_reg;
    logic                       out_na_reg;
    logic                       out_load;

    logic [SW-1:0]              st_idx;
    logic [HW-1:0]              head_cur, head_new;
    logic [FW-1:0]              fill_cur;
    logic [3:0]                 age;
    logic [CW-1:0]              ring;
    logic [HW-1:0]              rd_slot;
    logic                       age_ok;
    logic [ADDR_W-1:0]          base;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
    logic [stm_pkg::TIME_W-1:0] mem_rdata;
    logic [stm_pkg::TIME_W-1:0] ent_val;
    logic                       ent_good;
    logic [stm_pkg::CNT_W-1:0]  pidx;

    logic                       srt_clear, srt_ins;
    logic [stm_pkg::VAL_W-1:0]  srt_data, srt_rd;
    logic                       div_start, div_done;
    logic [stm_pkg::SUM_W-1:0]  div_quo;

    logic signed [6:0]          win_s, lo_s, hi_s, hi_eff, dv;
    logic                       in_rng;
    logic                       s_fire;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == stm_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // history addressing
    assign st_idx   = SW'(st_reg);
    assign head_cur = head_reg[st_idx];
    assign fill_cur = fill_reg[st_idx];
    assign head_new = (head_cur == HW'(HISTORY_DEPTH - 1)) ? '0 : head_cur + HW'(1);
    assign base     = ADDR_W'(ADDR_W'(st_idx) * ADDR_W'(HISTORY_DEPTH));
    assign age      = cnt_reg[3:0];
    assign age_ok   = (int'(age) < HISTORY_DEPTH) && (int'(age) < int'(fill_cur));

    always_comb
    begin
        ring = CW'(head_cur) + CW'(HISTORY_DEPTH) - CW'(age);
        if (ring >= CW'(HISTORY_DEPTH))
        begin
            ring = ring - CW'(HISTORY_DEPTH);
        end
        rd_slot = ring[HW-1:0];
    end

    assign mem_we    = (state_reg == stm_pkg::ST_WRITE);
    assign mem_waddr = base + ADDR_W'(head_new);
    assign mem_raddr = base + ADDR_W'(rd_slot);

    stm_hist_mem #(
        .DEPTH  (MDEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (sample_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // entry screening
    assign pidx     = cnt_reg - stm_pkg::CNT_W'(1);
    assign ent_val  = ent_ok_reg ? mem_rdata : '0;
    assign ent_good = (ent_val != '0) && (ent_val < stm_pkg::TIME_LIMIT);
    assign srt_data = ent_good ? ent_val[stm_pkg::VAL_W-1:0] : '0;
    assign srt_ins  = (state_reg == stm_pkg::ST_LOAD) && (cnt_reg != '0) && (pidx < win_reg);
    assign srt_clear = (state_reg == stm_pkg::ST_WRITE);

    stm_sort u_sort (
        .clk       (clk),
        .clear     (srt_clear),
        .ins_valid (srt_ins),
        .ins_data  (srt_data),
        .rd_idx    (cnt_reg[3:0]),
        .rd_data   (srt_rd)
    );

    assign div_start = (state_reg == stm_pkg::ST_DSTART);

    stm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (dvs_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // trim arithmetic
    always_comb
    begin
        win_s  = $signed({2'b00, win_reg});
        lo_s   = $signed({2'b00, lo_reg});
        hi_s   = $signed({3'b000, hi_reg});
        hi_eff = ((win_s - lo_s) <= hi_s) ? 7'sd0 : hi_s;
        dv     = win_s - hi_eff - lo_s;
    end

    assign in_rng = ({1'b0, cnt_reg[3:0]} >= lo_reg) && ({1'b0, cnt_reg[3:0]} < ub_reg);
    assign out_load = (state_reg == stm_pkg::ST_DONE) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next    = state_reg;
        st_next       = st_reg;
        sample_next   = sample_reg;
        win_next      = win_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        ub_next       = ub_reg;
        dvs_next      = dvs_reg;
        cnt_next      = cnt_reg;
        ent_ok_next   = ent_ok_reg;
        sum_next      = sum_reg;
        res_time_next = res_time_reg;
        res_na_next   = res_na_reg;
        case (state_reg)
            stm_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    st_next     = s_tdata[3:0];
                    sample_next = s_tdata[19:4];
                    if (int'(s_tdata[3:0]) < STATIONS)
                    begin
                        state_next = stm_pkg::ST_WRITE;
                    end
                    else
                    begin
                        res_time_next = '0;
                        res_na_next   = 1'b1;
                        state_next    = stm_pkg::ST_DONE;
                    end
                end
            end
            stm_pkg::ST_WRITE:
            begin
                win_next   = {1'b0, wcount_reg};
                lo_next    = {1'b0, tlow_reg};
                hi_next    = thigh_reg;
                cnt_next   = '0;
                state_next = stm_pkg::ST_LOAD;
            end
            stm_pkg::ST_LOAD:
            begin
                ent_ok_next = age_ok;
                if (srt_ins && !ent_good
                    && !(win_reg >= stm_pkg::GROW_LIMIT || win_reg == {1'b0, wcap_reg}))
                begin
                    win_next = win_reg + stm_pkg::CNT_W'(1);
                    lo_next  = lo_reg + stm_pkg::CNT_W'(1);
                end
                if (cnt_reg == stm_pkg::CNT_W'(stm_pkg::SLOTS))
                begin
                    state_next = stm_pkg::ST_TRIM;
                end
                else
                begin
                    cnt_next = cnt_reg + stm_pkg::CNT_W'(1);
                end
            end
            stm_pkg::ST_TRIM:
            begin
                cnt_next = '0;
                sum_next = '0;
                ub_next  = stm_pkg::CNT_W'(win_s - hi_eff);
                dvs_next = dv[3:0];
                if (dv <= 7'sd0)
                begin
                    res_time_next = '0;
                    res_na_next   = 1'b1;
                    state_next    = stm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = stm_pkg::ST_SUM;
                end
            end
            stm_pkg::ST_SUM:
            begin
                if (in_rng)
                begin
                    sum_next = sum_reg + stm_pkg::SUM_W'(srt_rd);
                end
                if (cnt_reg == stm_pkg::CNT_W'(stm_pkg::SLOTS - 1))
                begin
                    state_next = stm_pkg::ST_DSTART;
                end
                else
                begin
                    cnt_next = cnt_reg + stm_pkg::CNT_W'(1);
                end
            end
            stm_pkg::ST_DSTART:
            begin
                state_next = stm_pkg::ST_DIV;
            end
            stm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_time_next = div_quo[stm_pkg::VAL_W-1:0];
                    res_na_next   = 1'b0;
                    state_next    = stm_pkg::ST_DONE;
                end
            end
            stm_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = stm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            wcount_reg    <= 4'd5;
            tlow_reg      <= 4'd1;
            thigh_reg     <= 4'd1;
            wcap_reg      <= 4'd10;
            for (int s = 0; s < STATIONS; s++)
            begin
                head_reg[s] <= '0;
                fill_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    stm_pkg::CFG_WINDOW_COUNT: wcount_reg <= cfg_data;
                    stm_pkg::CFG_TRIM_LOW:     tlow_reg   <= cfg_data;
                    stm_pkg::CFG_TRIM_HIGH:    thigh_reg  <= cfg_data;
                    stm_pkg::CFG_WINDOW_CAP:   wcap_reg   <= cfg_data;
                    default:                   wcap_reg   <= wcap_reg;
                endcase
            end
            if (state_reg == stm_pkg::ST_WRITE)
            begin
                head_reg[st_idx] <= head_new;
                if (fill_cur != FW'(HISTORY_DEPTH))
                begin
                    fill_reg[st_idx] <= fill_cur + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg       <= st_next;
        sample_reg   <= sample_next;
        win_reg      <= win_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        ub_reg       <= ub_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        ent_ok_reg   <= ent_ok_next;
        sum_reg      <= sum_next;
        res_time_reg <= res_time_next;
        res_na_reg   <= res_na_next;
        if (out_load)
        begin
            out_st_reg   <= st_reg;
            out_time_reg <= res_time_reg;
            out_na_reg   <= res_na_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_time_reg, out_st_reg};
    assign m_tuser  = out_na_reg;

    `STM_ASSERT_NEXT(a_accept_path, s_fire,
        state_reg == stm_pkg::ST_WRITE || state_reg == stm_pkg::ST_DONE,
        "accepted item did not start processing")
    `STM_ASSERT_NOW(a_na_zero, m_tvalid && m_tuser[0], m_tdata[18:4] == '0,
        "no_average with nonzero filtered_time")
    `STM_ASSERT_NOW(a_time_range, m_tvalid, m_tdata[18:4] < stm_pkg::EMPTY_MARK,
        "filtered_time out of range")

endmodule
